FILE: hw/rtl/kpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kpq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int KEY_W   = 32;
  localparam int PAY_W   = 33;
  localparam int ENTRY_W = KEY_W + PAY_W;

  typedef struct packed {
    logic               command;
    logic signed [31:0] sort_key;
    logic               entry_kind;
    logic [15:0]        entry_index;
    logic [15:0]        entry_flag;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        out_kind;
    logic [15:0] out_index;
    logic [15:0] out_mask;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic               kind;
    logic [15:0]        index;
    logic [15:0]        flag;
  } entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module kpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/keyed_priority_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake            | payload          | beat
// cmd     | cmd_valid, cmd_ready | kpq_pkg::cmd_t   | insert or pop request
// rsp     | rsp_valid, rsp_ready | kpq_pkg::rsp_t   | one status beat per request
//
// insert, full insert or empty pop: accept, then result to the output register
// pop of n entries with the smallest at slot b: one read port of the entry ram, a scan of
// all slots, then a shift down of the slots after b; no shift when b is the last slot
// reset clears the fill count and the handshakes; the ram needs no clearing
// a stalled rsp holds the next result in the emit state; cmd is taken only when idle

module keyed_priority_queue_unit #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire kpq_pkg::cmd_t  cmd,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output kpq_pkg::rsp_t       rsp
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t           state;
  logic [CW-1:0]    count;
  logic [CW-1:0]    ra;
  logic             rd_valid;
  logic [AW-1:0]    rd_idx;
  logic [AW-1:0]    best_idx;
  kpq_pkg::entry_t  best;
  kpq_pkg::rsp_t    res;

  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [kpq_pkg::ENTRY_W-1:0]   wdata;
  logic [kpq_pkg::ENTRY_W-1:0]   rdata;
  kpq_pkg::entry_t               rd_entry;
  kpq_pkg::entry_t               in_entry;

  logic             rd_en;
  logic             take;
  logic             last;
  logic             emit;
  logic [AW-1:0]    best_idx_next;
  kpq_pkg::entry_t  best_next;
  logic [CW-1:0]    count_m1;

  assign cmd_ready = (state == ST_IDLE);
  assign rd_entry  = kpq_pkg::entry_t'(rdata);
  assign count_m1  = count - CW'(1);
  assign rd_en     = ((state == ST_SCAN) || (state == ST_SHIFT)) && (ra < count);
  assign last      = (CW'(rd_idx) == count_m1);
  assign emit      = (state == ST_EMIT) && (!rsp_valid || rsp_ready);

  assign in_entry.key   = cmd.sort_key;
  assign in_entry.kind  = cmd.entry_kind;
  assign in_entry.index = cmd.entry_index;
  assign in_entry.flag  = cmd.entry_flag;

  assign take          = (rd_idx == '0) || (rd_entry.key <= best.key);
  assign best_idx_next = take ? rd_idx : best_idx;
  assign best_next     = take ? rd_entry : best;

  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = in_entry;
    case (state)
      ST_IDLE: begin
        we = cmd_valid && (cmd.command == kpq_pkg::CMD_INSERT) &&
             (count < CW'(QUEUE_DEPTH));
      end
      ST_SHIFT: begin
        we    = rd_valid;
        waddr = rd_idx - AW'(1);
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  kpq_ram #(
    .WIDTH (kpq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ra[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      ra        <= '0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      if (rd_en) begin
        rd_idx <= ra[AW-1:0];
        ra     <= ra + CW'(1);
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.command == kpq_pkg::CMD_INSERT) begin
              if (count < CW'(QUEUE_DEPTH)) begin
                count <= count + CW'(1);
                res   <= {kpq_pkg::STATUS_OK, 33'h0};
              end else begin
                res <= {kpq_pkg::STATUS_FULL, 33'h0};
              end
              state <= ST_EMIT;
            end else if (count == '0) begin
              res   <= {kpq_pkg::STATUS_EMPTY, 33'h0};
              state <= ST_EMIT;
            end else begin
              ra    <= '0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_valid) begin
            best_idx <= best_idx_next;
            best     <= best_next;
            if (last) begin
              res <= {kpq_pkg::STATUS_OK, best_next.kind, best_next.index, best_next.flag};
              if (CW'(best_idx_next) == count_m1) begin
                count <= count_m1;
                state <= ST_EMIT;
              end else begin
                ra    <= CW'(best_idx_next) + CW'(1);
                state <= ST_SHIFT;
              end
            end
          end
        end
        ST_SHIFT: begin
          if (rd_valid && last) begin
            count <= count_m1;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            rsp   <= res;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
